// File: rtl/fpebu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpebu_pkg
// Shared types, constants and helper functions of the fp32 elementwise
// binary unit.
// ----------------------------------------------------------------------------
package fpebu_pkg;

   // Signed working exponent and the wide working significand.
   localparam int unsigned EXP_W = 11;
   localparam int unsigned R_W   = 50;
   localparam int unsigned LZ_W  = $clog2(R_W + 1);

   // Divider: quotient bits, bits per stage, stage count.
   localparam int unsigned Q_W        = 27;
   localparam int unsigned DIV_STEPS  = 3;
   localparam int unsigned DIV_STAGES = Q_W / DIV_STEPS;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [7:0]  EXP_MAX   = 8'hFF;

   // Configuration register indexes.
   localparam logic [1:0] CSR_OPERATION  = 2'd0;
   localparam logic [1:0] CSR_USE_SCALAR = 2'd1;
   localparam logic [1:0] CSR_SCALAR     = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_MAX  = 3'd4,
      OP_MIN  = 3'd5,
      OP_RSUB = 3'd6,
      OP_RDIV = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      CLS_ADD = 2'd0,
      CLS_MUL = 2'd1,
      CLS_DIV = 2'd2,
      CLS_SEL = 2'd3
   } cls_type;

   // Item state carried through the divider stages into the back end.
   typedef struct packed {
      logic                    is_div;
      logic                    sign;
      logic signed [EXP_W-1:0] exp;
      logic [R_W-1:0]          mant;
      logic                    sticky;
      logic                    special;
      logic [31:0]             special_bits;
      logic [24:0]             rem;
      logic [23:0]             den;
      logic [Q_W-1:0]          quo;
   } work_type;

   // Leading zero count; returns R_W for an all-zero word.
   function automatic logic [LZ_W-1:0] lead_zeros(input logic [R_W-1:0] v);
      logic [LZ_W-1:0] n;
      n = LZ_W'(R_W);
      for (int i = 0; i < R_W; i++) begin
         if (v[i]) begin
            n = LZ_W'(R_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/fpebu_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpebu_div_stage
// One register stage of the restoring divider: a few quotient bits per stage.
// Items that are not divisions pass through unchanged.
// ----------------------------------------------------------------------------
module fpebu_div_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fpebu_pkg::work_type in_work,
   output logic                out_valid,
   output fpebu_pkg::work_type out_work
);

   logic                       valid_ff;
   fpebu_pkg::work_type        work_ff;
   fpebu_pkg::work_type        work_in;
   logic [24:0]                rem_v;
   logic [fpebu_pkg::Q_W-1:0]  quo_v;

   always_comb begin
      work_in = in_work;
      rem_v   = in_work.rem;
      quo_v   = in_work.quo;
      for (int k = 0; k < fpebu_pkg::DIV_STEPS; k++) begin
         if (rem_v >= {1'b0, in_work.den}) begin
            rem_v = rem_v - {1'b0, in_work.den};
            quo_v = {quo_v[fpebu_pkg::Q_W-2:0], 1'b1};
         end else begin
            quo_v = {quo_v[fpebu_pkg::Q_W-2:0], 1'b0};
         end
         rem_v = {rem_v[23:0], 1'b0};
      end
      if (in_work.is_div) begin
         work_in.rem = rem_v;
         work_in.quo = quo_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// File: rtl/fpebu_norm_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpebu_norm_round
// Back end: leading zero count, normalize, subnormal shift, round to
// nearest even and pack, in four register stages.
// ----------------------------------------------------------------------------
module fpebu_norm_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fpebu_pkg::work_type in_work,
   output logic                out_valid,
   output logic [31:0]         out_value
);

   localparam int unsigned EW = fpebu_pkg::EXP_W;
   localparam int unsigned RW = fpebu_pkg::R_W;

   // B1: count
   logic                          b1_valid_ff;
   logic                          b1_sign_ff;
   logic signed [EW-1:0]          b1_exp_ff;
   logic [RW-1:0]                 b1_mant_ff;
   logic                          b1_sticky_ff;
   logic [fpebu_pkg::LZ_W-1:0]    b1_lz_ff;
   logic                          b1_special_ff;
   logic [31:0]                   b1_bits_ff;

   // B2: normalized
   logic                          b2_valid_ff;
   logic                          b2_sign_ff;
   logic signed [EW-1:0]          b2_exp_ff;
   logic [25:0]                   b2_m_ff;
   logic                          b2_sticky_ff;
   logic                          b2_special_ff;
   logic [31:0]                   b2_bits_ff;

   // B3: exponent field settled
   logic                          b3_valid_ff;
   logic                          b3_sign_ff;
   logic [7:0]                    b3_efield_ff;
   logic [25:0]                   b3_m_ff;
   logic                          b3_sticky_ff;
   logic                          b3_ovf_ff;
   logic                          b3_special_ff;
   logic [31:0]                   b3_bits_ff;

   // B4: output
   logic                          b4_valid_ff;
   logic [31:0]                   b4_value_ff;

   logic [RW-1:0]                 shifted_in;
   logic signed [EW-1:0]          exp_in;
   logic signed [EW-1:0]          dshift_full;
   logic [4:0]                    dshift;
   logic [25:0]                   dm;
   logic                          dlost;
   logic [7:0]                    efield_in;
   logic [25:0]                   m_in;
   logic                          sticky_in;
   logic                          ovf_in;
   logic                          round_up;
   logic [30:0]                   packed_sum;
   logic [31:0]                   value_in;

   // B2 combinational: shift leading one to the top.
   always_comb begin
      shifted_in = b1_mant_ff << b1_lz_ff;
      exp_in     = b1_exp_ff + EW'(1) - $signed({{(EW-fpebu_pkg::LZ_W){1'b0}}, b1_lz_ff});
   end

   // B3 combinational: subnormal right shift or overflow flag.
   always_comb begin
      dshift_full = EW'(1) - b2_exp_ff;
      dshift      = (dshift_full[EW-1:5] != '0) ? 5'd31 : dshift_full[4:0];
      dm          = b2_m_ff >> dshift;
      dlost       = ((dm << dshift) != b2_m_ff);
      if (b2_exp_ff < $signed(EW'(1))) begin
         efield_in = 8'd0;
         m_in      = dm;
         sticky_in = b2_sticky_ff | dlost;
         ovf_in    = 1'b0;
      end else begin
         efield_in = b2_exp_ff[7:0];
         m_in      = b2_m_ff;
         sticky_in = b2_sticky_ff;
         ovf_in    = (b2_exp_ff > $signed(EW'(254)));
      end
   end

   // B4 combinational: round to nearest even; carry runs into the exponent.
   always_comb begin
      round_up   = b3_m_ff[1] & (b3_m_ff[0] | b3_sticky_ff | b3_m_ff[2]);
      packed_sum = {b3_efield_ff, b3_m_ff[24:2]} + {30'd0, round_up};
      priority if (b3_special_ff) begin
         value_in = b3_bits_ff;
      end else if (b3_ovf_ff) begin
         value_in = {b3_sign_ff, fpebu_pkg::EXP_MAX, 23'd0};
      end else begin
         value_in = {b3_sign_ff, packed_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= in_valid;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end

      b1_sign_ff    <= in_work.sign;
      b1_exp_ff     <= in_work.exp;
      b1_mant_ff    <= in_work.mant;
      b1_sticky_ff  <= in_work.sticky;
      b1_lz_ff      <= fpebu_pkg::lead_zeros(in_work.mant);
      // An exact zero sum leaves as a signed zero.
      b1_special_ff <= in_work.special | (in_work.mant == '0);
      b1_bits_ff    <= in_work.special ? in_work.special_bits : {in_work.sign, 31'd0};

      b2_sign_ff    <= b1_sign_ff;
      b2_exp_ff     <= exp_in;
      b2_m_ff       <= shifted_in[RW-1:RW-26];
      b2_sticky_ff  <= (shifted_in[RW-27:0] != '0) | b1_sticky_ff;
      b2_special_ff <= b1_special_ff;
      b2_bits_ff    <= b1_bits_ff;

      b3_sign_ff    <= b2_sign_ff;
      b3_efield_ff  <= efield_in;
      b3_m_ff       <= m_in;
      b3_sticky_ff  <= sticky_in;
      b3_ovf_ff     <= ovf_in;
      b3_special_ff <= b2_special_ff;
      b3_bits_ff    <= b2_bits_ff;

      b4_value_ff   <= value_in;
   end

   assign out_valid = b4_valid_ff;
   assign out_value = b4_value_ff;

endmodule

// File: rtl/fp32_elementwise_binary_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_elementwise_binary_unit_core
// Elementwise binary operation on IEEE single-precision items: add, sub,
// mul, div, max, min, reverse sub and reverse div, round to nearest even.
// ----------------------------------------------------------------------------
//
//   channel   ports                                    handshake
//   -------   --------------------------------------   ------------------------
//   request   req_operand_a, req_operand_b             start high, busy low
//   response  rsp_result_value                         rsp_valid, one cycle
//   config    csr_index, csr_write_data                csr_write_enable
//
// One item enters every cycle; busy stays low. Each result is strobed on
// rsp_valid after its item has passed the pipeline depth of 17 registers:
// 4 front stages, 9 divider stages of 3 quotient bits each, 4 back stages.
// All operations run the same depth, so results leave in order.
// Synchronous reset clears the valid bits and the configuration registers.
// The receiver cannot stall; nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module fp32_elementwise_binary_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_value,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned EW = fpebu_pkg::EXP_W;
   localparam int unsigned RW = fpebu_pkg::R_W;
   localparam int unsigned NS = fpebu_pkg::DIV_STAGES;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   fpebu_pkg::op_type operation_ff;
   logic              use_scalar_ff;
   logic [31:0]       scalar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff  <= fpebu_pkg::OP_ADD;
         use_scalar_ff <= 1'b0;
         scalar_ff     <= 32'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fpebu_pkg::CSR_OPERATION: begin
               operation_ff <= fpebu_pkg::op_type'(csr_write_data[2:0]);
            end
            fpebu_pkg::CSR_USE_SCALAR: begin
               use_scalar_ff <= csr_write_data[0];
            end
            fpebu_pkg::CSR_SCALAR: begin
               scalar_ff <= csr_write_data;
            end
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   // The pipeline never holds, so an item is always taken.
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // S1: pick operands. Reverse ops swap them; subtraction flips the sign
   // of the second operand so the adder only ever adds signed values.
   // ---------------------------------------------------------------------
   logic [31:0]        b_src;
   logic [31:0]        x_in;
   logic [31:0]        y_in;
   fpebu_pkg::cls_type cls_in;

   always_comb begin
      b_src = use_scalar_ff ? scalar_ff : req_operand_b;
      x_in  = req_operand_a;
      y_in  = b_src;
      unique case (operation_ff)
         fpebu_pkg::OP_ADD:  cls_in = fpebu_pkg::CLS_ADD;
         fpebu_pkg::OP_SUB: begin
            cls_in = fpebu_pkg::CLS_ADD;
            y_in   = {~b_src[31], b_src[30:0]};
         end
         fpebu_pkg::OP_MUL:  cls_in = fpebu_pkg::CLS_MUL;
         fpebu_pkg::OP_DIV:  cls_in = fpebu_pkg::CLS_DIV;
         fpebu_pkg::OP_MAX:  cls_in = fpebu_pkg::CLS_SEL;
         fpebu_pkg::OP_MIN:  cls_in = fpebu_pkg::CLS_SEL;
         fpebu_pkg::OP_RSUB: begin
            cls_in = fpebu_pkg::CLS_ADD;
            x_in   = b_src;
            y_in   = {~req_operand_a[31], req_operand_a[30:0]};
         end
         fpebu_pkg::OP_RDIV: begin
            cls_in = fpebu_pkg::CLS_DIV;
            x_in   = b_src;
            y_in   = req_operand_a;
         end
         default: cls_in = fpebu_pkg::CLS_ADD;
      endcase
   end

   logic               s1_valid_ff;
   fpebu_pkg::cls_type s1_cls_ff;
   logic               s1_is_min_ff;
   logic [31:0]        s1_x_ff;
   logic [31:0]        s1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_cls_ff    <= cls_in;
      s1_is_min_ff <= (operation_ff == fpebu_pkg::OP_MIN);
      s1_x_ff      <= x_in;
      s1_y_ff      <= y_in;
   end

   // ---------------------------------------------------------------------
   // S2: unpack, special cases, max/min select, magnitude order for add,
   // significand product for mul, leading zeros for div.
   // ---------------------------------------------------------------------
   logic        sx, sy;
   logic [7:0]  ex, ey, ex_eff, ey_eff;
   logic [22:0] fx, fy;
   logic [23:0] mx, my;
   logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
   logic        x_lt_y, y_lt_x, x_big;
   logic        spec_in;
   logic [31:0] spec_bits_in;
   logic        sxor;

   always_comb begin
      sx     = s1_x_ff[31];
      sy     = s1_y_ff[31];
      ex     = s1_x_ff[30:23];
      ey     = s1_y_ff[30:23];
      fx     = s1_x_ff[22:0];
      fy     = s1_y_ff[22:0];
      ex_eff = (ex == 8'd0) ? 8'd1 : ex;
      ey_eff = (ey == 8'd0) ? 8'd1 : ey;
      mx     = {ex != 8'd0, fx};
      my     = {ey != 8'd0, fy};
      x_nan  = (ex == fpebu_pkg::EXP_MAX) && (fx != 23'd0);
      y_nan  = (ey == fpebu_pkg::EXP_MAX) && (fy != 23'd0);
      x_inf  = (ex == fpebu_pkg::EXP_MAX) && (fx == 23'd0);
      y_inf  = (ey == fpebu_pkg::EXP_MAX) && (fy == 23'd0);
      x_zero = (s1_x_ff[30:0] == 31'd0);
      y_zero = (s1_y_ff[30:0] == 31'd0);
      sxor   = sx ^ sy;
      x_big  = (s1_x_ff[30:0] >= s1_y_ff[30:0]);

      // Ordered compare: false with a NaN, and +0 equals -0.
      x_lt_y = 1'b0;
      y_lt_x = 1'b0;
      if (!x_nan && !y_nan && !(x_zero && y_zero)) begin
         priority if (sx != sy) begin
            x_lt_y = sx;
            y_lt_x = sy;
         end else if (!sx) begin
            x_lt_y = (s1_x_ff[30:0] < s1_y_ff[30:0]);
            y_lt_x = (s1_y_ff[30:0] < s1_x_ff[30:0]);
         end else begin
            x_lt_y = (s1_x_ff[30:0] > s1_y_ff[30:0]);
            y_lt_x = (s1_y_ff[30:0] > s1_x_ff[30:0]);
         end
      end

      spec_in      = 1'b0;
      spec_bits_in = fpebu_pkg::QNAN_BITS;
      unique case (s1_cls_ff)
         fpebu_pkg::CLS_ADD: begin
            priority if (x_nan || y_nan || (x_inf && y_inf && sxor)) begin
               spec_in = 1'b1;
            end else if (x_inf) begin
               spec_in      = 1'b1;
               spec_bits_in = {sx, fpebu_pkg::EXP_MAX, 23'd0};
            end else if (y_inf) begin
               spec_in      = 1'b1;
               spec_bits_in = {sy, fpebu_pkg::EXP_MAX, 23'd0};
            end else begin
               spec_in = 1'b0;
            end
         end
         fpebu_pkg::CLS_MUL: begin
            priority if (x_nan || y_nan || (x_inf && y_zero) || (x_zero && y_inf)) begin
               spec_in = 1'b1;
            end else if (x_inf || y_inf) begin
               spec_in      = 1'b1;
               spec_bits_in = {sxor, fpebu_pkg::EXP_MAX, 23'd0};
            end else if (x_zero || y_zero) begin
               spec_in      = 1'b1;
               spec_bits_in = {sxor, 31'd0};
            end else begin
               spec_in = 1'b0;
            end
         end
         fpebu_pkg::CLS_DIV: begin
            priority if (x_nan || y_nan || (x_zero && y_zero) || (x_inf && y_inf)) begin
               spec_in = 1'b1;
            end else if (x_inf || y_zero) begin
               spec_in      = 1'b1;
               spec_bits_in = {sxor, fpebu_pkg::EXP_MAX, 23'd0};
            end else if (y_inf || x_zero) begin
               spec_in      = 1'b1;
               spec_bits_in = {sxor, 31'd0};
            end else begin
               spec_in = 1'b0;
            end
         end
         fpebu_pkg::CLS_SEL: begin
            // Select passes the chosen operand bit for bit.
            spec_in = 1'b1;
            if (s1_is_min_ff) begin
               spec_bits_in = y_lt_x ? s1_y_ff : s1_x_ff;
            end else begin
               spec_bits_in = x_lt_y ? s1_y_ff : s1_x_ff;
            end
         end
         default: spec_in = 1'b1;
      endcase
   end

   logic               s2_valid_ff;
   fpebu_pkg::cls_type s2_cls_ff;
   logic               s2_sign_big_ff;
   logic               s2_sign_small_ff;
   logic               s2_sxor_ff;
   logic [7:0]         s2_exp_big_ff;
   logic [23:0]        s2_man_big_ff;
   logic [23:0]        s2_man_small_ff;
   logic [7:0]         s2_diff_ff;
   logic [47:0]        s2_prod_ff;
   logic [7:0]         s2_ex_ff;
   logic [7:0]         s2_ey_ff;
   logic [23:0]        s2_mx_ff;
   logic [23:0]        s2_my_ff;
   logic [4:0]         s2_lzx_ff;
   logic [4:0]         s2_lzy_ff;
   logic               s2_special_ff;
   logic [31:0]        s2_bits_ff;
   logic [fpebu_pkg::LZ_W-1:0] lzx_full, lzy_full;

   always_comb begin
      lzx_full = fpebu_pkg::lead_zeros({mx, {(RW-24){1'b0}}});
      lzy_full = fpebu_pkg::lead_zeros({my, {(RW-24){1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_cls_ff        <= s1_cls_ff;
      s2_sign_big_ff   <= x_big ? sx : sy;
      s2_sign_small_ff <= x_big ? sy : sx;
      s2_sxor_ff       <= sxor;
      s2_exp_big_ff    <= x_big ? ex_eff : ey_eff;
      s2_man_big_ff    <= x_big ? mx : my;
      s2_man_small_ff  <= x_big ? my : mx;
      s2_diff_ff       <= x_big ? (ex_eff - ey_eff) : (ey_eff - ex_eff);
      s2_prod_ff       <= mx * my;
      s2_ex_ff         <= ex_eff;
      s2_ey_ff         <= ey_eff;
      s2_mx_ff         <= mx;
      s2_my_ff         <= my;
      s2_lzx_ff        <= lzx_full[4:0];
      s2_lzy_ff        <= lzy_full[4:0];
      s2_special_ff    <= spec_in;
      s2_bits_ff       <= spec_bits_in;
   end

   // ---------------------------------------------------------------------
   // S3: align the smaller addend (jam shifted-out bits into its LSB),
   // place the product, normalize the divider operands.
   // ---------------------------------------------------------------------
   logic [48:0]   small_wide;
   logic [5:0]    shamt;
   logic [48:0]   small_shifted;
   logic          small_lost;
   logic [EW-1:0] exp_s3;
   logic [RW-1:0] mant_s3;

   always_comb begin
      small_wide    = {s2_man_small_ff, 25'd0};
      shamt         = (s2_diff_ff > 8'd63) ? 6'd63 : s2_diff_ff[5:0];
      small_shifted = small_wide >> shamt;
      small_lost    = ((small_shifted << shamt) != small_wide);
      unique case (s2_cls_ff)
         fpebu_pkg::CLS_MUL: begin
            exp_s3  = {3'd0, s2_ex_ff} + {3'd0, s2_ey_ff} - EW'(125);
            mant_s3 = {2'd0, s2_prod_ff};
         end
         fpebu_pkg::CLS_DIV: begin
            exp_s3  = {3'd0, s2_ex_ff} - {6'd0, s2_lzx_ff} - {3'd0, s2_ey_ff}
                      + {6'd0, s2_lzy_ff} + EW'(127);
            mant_s3 = '0;
         end
         default: begin
            exp_s3  = {3'd0, s2_exp_big_ff};
            mant_s3 = '0;
         end
      endcase
   end

   logic                 s3_valid_ff;
   fpebu_pkg::cls_type   s3_cls_ff;
   logic                 s3_sign_ff;
   logic                 s3_sign_small_ff;
   logic                 s3_sub_ff;
   logic signed [EW-1:0] s3_exp_ff;
   logic [23:0]          s3_big_ff;
   logic [48:0]          s3_aligned_ff;
   logic [RW-1:0]        s3_mant_ff;
   logic [23:0]          s3_nx_ff;
   logic [23:0]          s3_ny_ff;
   logic                 s3_special_ff;
   logic [31:0]          s3_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_cls_ff        <= s2_cls_ff;
      s3_sign_ff       <= (s2_cls_ff == fpebu_pkg::CLS_ADD) ? s2_sign_big_ff : s2_sxor_ff;
      s3_sign_small_ff <= s2_sign_small_ff;
      s3_sub_ff        <= s2_sign_big_ff ^ s2_sign_small_ff;
      s3_exp_ff        <= $signed(exp_s3);
      s3_big_ff        <= s2_man_big_ff;
      s3_aligned_ff    <= {small_shifted[48:1], small_shifted[0] | small_lost};
      s3_mant_ff       <= mant_s3;
      s3_nx_ff         <= s2_mx_ff << s2_lzx_ff;
      s3_ny_ff         <= s2_my_ff << s2_lzy_ff;
      s3_special_ff    <= s2_special_ff;
      s3_bits_ff       <= s2_bits_ff;
   end

   // ---------------------------------------------------------------------
   // S4: add or subtract aligned significands; seed the divider.
   // ---------------------------------------------------------------------
   logic [RW-1:0]       big_wide;
   logic [RW-1:0]       small_al;
   logic [RW-1:0]       sum;
   fpebu_pkg::work_type work_s4;

   always_comb begin
      big_wide = {1'b0, s3_big_ff, 25'd0};
      small_al = {1'b0, s3_aligned_ff};
      sum      = s3_sub_ff ? (big_wide - small_al) : (big_wide + small_al);

      work_s4              = '0;
      work_s4.is_div       = (s3_cls_ff == fpebu_pkg::CLS_DIV) && !s3_special_ff;
      work_s4.sign         = s3_sign_ff;
      work_s4.exp          = s3_exp_ff;
      work_s4.special      = s3_special_ff;
      work_s4.special_bits = s3_bits_ff;
      work_s4.rem          = {1'b0, s3_nx_ff};
      work_s4.den          = s3_ny_ff;
      unique case (s3_cls_ff)
         fpebu_pkg::CLS_ADD: begin
            work_s4.mant = sum;
            // exact cancellation gives +0 unless both addends were -0
            if (sum == '0) begin
               work_s4.sign = s3_sign_ff & s3_sign_small_ff;
            end
         end
         fpebu_pkg::CLS_MUL: work_s4.mant = s3_mant_ff;
         default:            work_s4.mant = {1'b1, {(RW-1){1'b0}}};
      endcase
   end

   logic                s4_valid_ff;
   fpebu_pkg::work_type s4_work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_work_ff <= work_s4;
   end

   // ---------------------------------------------------------------------
   // Divider chain: every stage retires a few quotient bits.
   // ---------------------------------------------------------------------
   logic                valid_chain [NS+1];
   fpebu_pkg::work_type work_chain  [NS+1];

   assign valid_chain[0] = s4_valid_ff;
   assign work_chain[0]  = s4_work_ff;

   for (genvar g = 0; g < NS; g++) begin : g_div
      fpebu_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[g]),
         .in_work   (work_chain[g]),
         .out_valid (valid_chain[g+1]),
         .out_work  (work_chain[g+1])
      );
   end

   // Place the quotient: its top bit weighs 1; a nonzero remainder is sticky.
   fpebu_pkg::work_type work_back;

   always_comb begin
      work_back = work_chain[NS];
      if (work_chain[NS].is_div) begin
         work_back.mant   = {1'b0, work_chain[NS].quo, {(RW-1-fpebu_pkg::Q_W){1'b0}}};
         work_back.sticky = (work_chain[NS].rem != '0);
      end
   end

   // ---------------------------------------------------------------------
   // Back end: normalize, round, pack; drive the response.
   // ---------------------------------------------------------------------
   fpebu_norm_round u_norm_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[NS]),
      .in_work   (work_back),
      .out_valid (rsp_valid),
      .out_value (rsp_result_value)
   );

endmodule
